// ----- hdl/pts_pkg.sv -----
// ----------------------------------------------------------------------------
// Pixel template search: shared definitions
// Widths, template constants and the template lookup used by the match cells.
// ----------------------------------------------------------------------------
package pts_pkg;

   localparam int TEMPLATE_LEN      = 8;
   localparam int NUM_TEMPLATES     = 4;
   localparam int DEFINED_TEMPLATES = 4;
   localparam int DEFINED_PIXELS    = 8;
   localparam int BASE_TEMPLATES    = 2;
   localparam int PIXEL_W           = 24;
   localparam int POS_W             = $clog2(TEMPLATE_LEN);
   localparam int FILL_W            = POS_W;
   localparam int FILL_MAX          = TEMPLATE_LEN - 1;

   typedef logic [PIXEL_W-1:0]       pixel_type;
   typedef logic [NUM_TEMPLATES-1:0] tmask_type;
   typedef logic [POS_W-1:0]         pos_type;
   typedef logic [FILL_W-1:0]        fill_type;

   // Templates, first pixel of the pattern first.
   localparam pixel_type TEMPLATE_ROM [DEFINED_TEMPLATES][DEFINED_PIXELS] = '{
      '{24'h001D26, 24'h001E27, 24'h30828D, 24'h003843,
        24'h298793, 24'h004E5C, 24'h218594, 24'h005C6A},
      '{24'h015682, 24'h013856, 24'h031D2B, 24'h03131C,
        24'h000D15, 24'h001724, 24'h002B43, 24'h014C73},
      '{24'h01283D, 24'h012D45, 24'h014265, 24'h015B89,
        24'h016495, 24'h015986, 24'h013F60, 24'h012C44},
      '{24'h031E2E, 24'h062131, 24'h01486C, 24'h016090,
        24'h02314B, 24'h082333, 24'h082333, 24'h07283A}
   };

   // Pattern positions past the defined pixels compare against black.
   function automatic pixel_type template_pixel(input int t, input pos_type p);
      pixel_type result;
      result = '0;
      if (t < DEFINED_TEMPLATES && int'(p) < DEFINED_PIXELS) begin
         result = TEMPLATE_ROM[t][p];
      end
      return result;
   endfunction

endpackage

// ----- hdl/pts_req_if.sv -----
// ----------------------------------------------------------------------------
// Pixel template search: pixel channel
// Valid/ready channel carrying one pixel word and its end-of-frame mark.
// ----------------------------------------------------------------------------
interface pts_req_if;
   logic                        valid;
   logic                        ready;
   logic [pts_pkg::PIXEL_W-1:0] pixel_rgb;
   logic                        frame_end;

   modport source (output valid, output pixel_rgb, output frame_end, input ready);
   modport sink   (input valid, input pixel_rgb, input frame_end, output ready);
endinterface

// ----- hdl/pts_rsp_if.sv -----
// ----------------------------------------------------------------------------
// Pixel template search: result channel
// Valid/ready channel carrying the per-frame found flag.
// ----------------------------------------------------------------------------
interface pts_rsp_if;
   logic valid;
   logic ready;
   logic template_found;

   modport source (output valid, output template_found, input ready);
   modport sink   (input valid, input template_found, output ready);
endinterface

// ----- hdl/pixel_template_search_core.sv -----
// ----------------------------------------------------------------------------
// Pixel template search core
// Slides an eight-pixel window over a pixel stream and reports per frame
// whether any enabled template matched.
// ----------------------------------------------------------------------------
//  Channel  Dir  Payload                    Word moved when
//  req      in   pixel_rgb, frame_end       req.valid && req.ready
//  rsp      out  template_found             rsp.valid && rsp.ready
//  csr      in   csr_write_data (1 bit)     csr_write_enable
//
//  One pixel word is accepted per cycle while req.ready is high. A word
//  enters the window chain on acceptance and is compared in the following
//  cycle against all templates. The result of a frame-end word passes the
//  compare stage and then the result register, from which rsp presents it.
//  A frame-end word waits in the compare stage while the result register is
//  still held by rsp; req.ready drops only then. Reset clears control state.
// ----------------------------------------------------------------------------
module pixel_template_search_core (
   input  logic       clock,
   input  logic       reset,
   pts_req_if.sink    req,
   pts_rsp_if.source  rsp,
   input  logic       csr_write_enable,
   input  logic       csr_write_data
);
   import pts_pkg::*;

   logic      enable_ff, enable_in;
   fill_type  fill_count_ff, fill_count_in;
   logic      s1_valid_ff, s1_valid_in;
   logic      s1_last_ff, s1_last_in;
   logic      s1_full_ff, s1_full_in;
   logic      match_seen_ff, match_seen_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_found_ff, rsp_found_in;

   logic      accept;
   logic      out_free;
   logic      s1_advance;
   logic      hit;
   tmask_type active;

   pixel_type window [TEMPLATE_LEN];
   tmask_type chain  [TEMPLATE_LEN+1];

   // Window chain: cell 0 holds the newest pixel.
   assign chain[0] = '1;

   for (genvar k = 0; k < TEMPLATE_LEN; k++) begin : g_cell
      pts_cell u_cell (
         .clock      (clock),
         .shift      (accept),
         .prev_pixel ((k == 0) ? req.pixel_rgb : window[(k == 0) ? 0 : k-1]),
         .tpl_pos    (POS_W'(TEMPLATE_LEN - 1 - k)),
         .match_prev (chain[k]),
         .pixel      (window[k]),
         .match_next (chain[k+1])
      );
   end

   for (genvar t = 0; t < NUM_TEMPLATES; t++) begin : g_act
      assign active[t] = (t < DEFINED_TEMPLATES) && ((t < BASE_TEMPLATES) || enable_ff);
   end

   assign out_free   = !rsp_valid_ff || rsp.ready;
   assign s1_advance = s1_valid_ff && (!s1_last_ff || out_free);
   assign req.ready  = !s1_valid_ff || s1_advance;
   assign accept     = req.valid && req.ready;
   assign hit        = s1_full_ff && |(chain[TEMPLATE_LEN] & active);

   always_comb begin
      enable_in     = csr_write_enable ? csr_write_data : enable_ff;

      fill_count_in = fill_count_ff;
      s1_valid_in   = s1_valid_ff && !s1_advance;
      s1_last_in    = s1_last_ff;
      s1_full_in    = s1_full_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
         s1_last_in  = req.frame_end;
         s1_full_in  = (fill_count_ff == FILL_W'(FILL_MAX));
         if (req.frame_end) begin
            fill_count_in = '0;
         end else if (fill_count_ff != FILL_W'(FILL_MAX)) begin
            fill_count_in = fill_count_ff + 1'b1;
         end
      end

      match_seen_in = match_seen_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_found_in  = rsp_found_ff;
      if (s1_advance) begin
         if (s1_last_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_found_in  = match_seen_ff || hit;
            match_seen_in = 1'b0;
         end else begin
            match_seen_in = match_seen_ff || hit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff     <= 1'b0;
         fill_count_ff <= '0;
         s1_valid_ff   <= 1'b0;
         match_seen_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         enable_ff     <= enable_in;
         fill_count_ff <= fill_count_in;
         s1_valid_ff   <= s1_valid_in;
         match_seen_ff <= match_seen_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_last_ff   <= s1_last_in;
      s1_full_ff   <= s1_full_in;
      rsp_found_ff <= rsp_found_in;
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.template_found = rsp_found_ff;

   // A new result word appears only after a frame-end word left the compare stage.
   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff)) |-> $past(s1_valid_ff && s1_last_ff))
      else $error("result word without a frame-end word");

   a_fill_restart: assert property (@(posedge clock) disable iff (reset)
      (accept && req.frame_end) |=> (fill_count_ff == '0))
      else $error("fill count not cleared at frame end");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_count_ff <= FILL_W'(FILL_MAX))
      else $error("fill count past window length");

   // The sticky flag is clear right after a frame-end word is reported.
   a_match_clear: assert property (@(posedge clock) disable iff (reset)
      (s1_advance && s1_last_ff) |=> !match_seen_ff)
      else $error("match flag survived frame end");

endmodule

// ----- hdl/pts_cell.sv -----
// ----------------------------------------------------------------------------
// Pixel template search: window cell
// Holds one window pixel, passes it on when the window shifts, and narrows
// the per-template match vector coming down the chain.
// ----------------------------------------------------------------------------
module pts_cell (
   input  logic                clock,
   input  logic                shift,
   input  pts_pkg::pixel_type  prev_pixel,
   input  pts_pkg::pos_type    tpl_pos,
   input  pts_pkg::tmask_type  match_prev,
   output pts_pkg::pixel_type  pixel,
   output pts_pkg::tmask_type  match_next
);
   import pts_pkg::*;

   pixel_type pixel_ff;
   pixel_type pixel_in;
   tmask_type local_eq;

   assign pixel_in = shift ? prev_pixel : pixel_ff;

   always_ff @(posedge clock) begin
      pixel_ff <= pixel_in;
   end

   for (genvar t = 0; t < NUM_TEMPLATES; t++) begin : g_cmp
      assign local_eq[t] = (pixel_ff == template_pixel(t, tpl_pos));
   end

   assign pixel      = pixel_ff;
   assign match_next = match_prev & local_eq;

endmodule

// ----- tb/tb_pixel_template_search_core.sv -----
// ----------------------------------------------------------------------------
// Pixel template search core testbench
// Streams frames of pixel words through the core and predicts, per frame,
// whether an enabled template appeared in any eight-pixel window. Directed
// frames cover single-pixel and short frames, a window that ends on the
// frame-end word, pattern halves split across frames, and a match recorded
// before the extra templates are switched off. Random frames with embedded,
// corrupted and partial templates follow, under random sender gaps, receiver
// stalls and register settings.
// ----------------------------------------------------------------------------
module tb_pixel_template_search_core;
   import pts_pkg::*;

   localparam int WIN           = 8;
   localparam int PATTERNS      = 4;
   localparam int BASE_PATTERNS = 2;
   localparam int N_ITEMS       = 2000;
   localparam int TAIL_ITEMS    = 300;
   localparam int SETTLE_CYCLES = 8;
   localparam int MAX_REPORTS   = 10;

   // Search patterns, first pixel first, written as red, green, blue.
   localparam pixel_type PATTERN_RGB [PATTERNS][WIN] = '{
      '{{8'd0, 8'd29, 8'd38},   {8'd0, 8'd30, 8'd39},   {8'd48, 8'd130, 8'd141},
        {8'd0, 8'd56, 8'd67},   {8'd41, 8'd135, 8'd147}, {8'd0, 8'd78, 8'd92},
        {8'd33, 8'd133, 8'd148}, {8'd0, 8'd92, 8'd106}},
      '{{8'd1, 8'd86, 8'd130},  {8'd1, 8'd56, 8'd86},   {8'd3, 8'd29, 8'd43},
        {8'd3, 8'd19, 8'd28},   {8'd0, 8'd13, 8'd21},   {8'd0, 8'd23, 8'd36},
        {8'd0, 8'd43, 8'd67},   {8'd1, 8'd76, 8'd115}},
      '{{8'd1, 8'd40, 8'd61},   {8'd1, 8'd45, 8'd69},   {8'd1, 8'd66, 8'd101},
        {8'd1, 8'd91, 8'd137},  {8'd1, 8'd100, 8'd149}, {8'd1, 8'd89, 8'd134},
        {8'd1, 8'd63, 8'd96},   {8'd1, 8'd44, 8'd68}},
      '{{8'd3, 8'd30, 8'd46},   {8'd6, 8'd33, 8'd49},   {8'd1, 8'd72, 8'd108},
        {8'd1, 8'd96, 8'd144},  {8'd2, 8'd49, 8'd75},   {8'd8, 8'd35, 8'd51},
        {8'd8, 8'd35, 8'd51},   {8'd7, 8'd40, 8'd58}}
   };

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic csr_write_data;

   pts_req_if pix_ch();
   pts_rsp_if found_ch();

   pixel_template_search_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .req              (pix_ch),
      .rsp              (found_ch),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // Predicted state of the core.
   pixel_type   window_q [WIN];
   int unsigned fill_level;
   bit          match_seen;
   bit          extra_on;
   bit          found_q [$];

   pixel_type   frame_q [$];
   bit          sender_idles;
   bit          receiver_idles;
   int unsigned words_sent;
   int unsigned frames_done;
   int unsigned frames_found;
   int unsigned csr_writes;
   int unsigned results_checked;
   int unsigned fail_count;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("tb_pixel_template_search_core NOT OK");
      $finish;
   end

   function automatic bit window_is(int t);
      for (int k = 0; k < WIN; k++) begin
         if (window_q[WIN-1-k] !== PATTERN_RGB[t][k]) begin
            return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   function automatic void track_pixel(pixel_type pix, bit last);
      for (int i = WIN - 1; i > 0; i--) begin
         window_q[i] = window_q[i-1];
      end
      window_q[0] = pix;
      // Only windows made wholly of pixels from this frame are compared.
      if (fill_level >= WIN - 1) begin
         for (int t = 0; t < PATTERNS; t++) begin
            if ((t < BASE_PATTERNS || extra_on) && window_is(t)) begin
               match_seen = 1'b1;
            end
         end
      end
      if (last) begin
         found_q = {found_q, match_seen};
         frames_done++;
         if (match_seen) begin
            frames_found++;
         end
         fill_level = 0;
         match_seen = 1'b0;
      end else if (fill_level < WIN - 1) begin
         fill_level++;
      end
   endfunction

   task automatic send_word(pixel_type pix, bit last);
      int gap;
      if (sender_idles && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 15);
         @(negedge clock);
         pix_ch.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      pix_ch.valid     <= 1'b1;
      pix_ch.pixel_rgb <= pix;
      pix_ch.frame_end <= last;
      do @(posedge clock); while (pix_ch.ready !== 1'b1);
      track_pixel(pix, last);
      words_sent++;
   endtask

   // Waits until every frame result is in and the compare stage is empty.
   task automatic settle();
      @(negedge clock);
      pix_ch.valid <= 1'b0;
      while (found_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_extra(bit value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      extra_on = value;
      csr_writes++;
   endtask

   function automatic pixel_type flip_bit(pixel_type pix);
      return pix ^ (pixel_type'(1) << $urandom_range(0, PIXEL_W - 1));
   endfunction

   function automatic pixel_type noise_pixel();
      int t;
      int k;
      t = $urandom_range(0, PATTERNS - 1);
      k = $urandom_range(0, WIN - 1);
      case ($urandom_range(0, 5))
         0: return PATTERN_RGB[t][k];
         1: return flip_bit(PATTERN_RGB[t][k]);
         2: return '0;
         3: return '1;
         default: return pixel_type'($urandom);
      endcase
   endfunction

   // Builds one frame: mostly short, with whole, corrupted or partial patterns.
   task automatic build_frame();
      int len;
      int at;
      int t;
      int part;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 80) : $urandom_range(1, 24);
      frame_q.delete();
      repeat (len) frame_q = {frame_q, noise_pixel()};
      if (len >= WIN) begin
         repeat ($urandom_range(0, 2)) begin
            t  = $urandom_range(0, PATTERNS - 1);
            at = $urandom_range(0, len - WIN);
            for (int k = 0; k < WIN; k++) begin
               frame_q[at+k] = PATTERN_RGB[t][k];
            end
            if ($urandom_range(0, 3) == 0) begin
               at = at + $urandom_range(0, WIN - 1);
               frame_q[at] = flip_bit(frame_q[at]);
            end
         end
      end
      // A pattern tail at the start or a head at the end of a frame lets
      // halves from neighboring frames line up in the window.
      if ($urandom_range(0, 3) == 0) begin
         t    = $urandom_range(0, PATTERNS - 1);
         part = $urandom_range(1, WIN - 1);
         for (int i = 0; i < part && i < len; i++) begin
            frame_q[i] = PATTERN_RGB[t][WIN-part+i];
         end
      end
      if ($urandom_range(0, 3) == 0) begin
         t    = $urandom_range(0, PATTERNS - 1);
         part = (len < WIN) ? len : $urandom_range(1, WIN - 1);
         for (int i = 0; i < part; i++) begin
            frame_q[len-part+i] = PATTERN_RGB[t][i];
         end
      end
   endtask

   task automatic send_next_word();
      pixel_type pix;
      if (frame_q.size() == 0) begin
         build_frame();
      end
      pix = frame_q.pop_front();
      send_word(pix, frame_q.size() == 0);
   endtask

   task automatic test_directed_frames();
      sender_idles   = 1'b0;
      receiver_idles = 1'b0;
      // A frame of a single white pixel.
      send_word('1, 1'b1);
      // A pattern whose window ends on the frame-end word.
      for (int k = 0; k < WIN; k++) begin
         send_word(PATTERN_RGB[0][k], k == WIN - 1);
      end
      // A pattern split over two frames must not match.
      for (int k = 0; k < WIN / 2; k++) begin
         send_word(PATTERN_RGB[1][k], k == WIN / 2 - 1);
      end
      for (int k = WIN / 2; k < WIN; k++) begin
         send_word(PATTERN_RGB[1][k], k == WIN - 1);
      end
      settle();
      // A match found with the extra patterns on stays found after they go off.
      write_extra(1'b1);
      for (int k = 0; k < WIN; k++) begin
         send_word(PATTERN_RGB[2][k], 1'b0);
      end
      settle();
      write_extra(1'b0);
      send_word('0, 1'b1);
      settle();
   endtask

   task automatic test_random_frames(int unsigned target);
      int unsigned mode;
      while (words_sent < target) begin
         settle();
         write_extra($urandom_range(0, 1));
         mode           = $urandom_range(0, 3);
         sender_idles   = mode[0];
         receiver_idles = mode[1];
         repeat ($urandom_range(40, 200)) send_next_word();
      end
   endtask

   task automatic test_quiet_tail(int unsigned count);
      sender_idles   = 1'b0;
      receiver_idles = 1'b0;
      repeat (count) send_next_word();
      while (frame_q.size() != 0) send_next_word();
      settle();
   endtask

   initial begin : rsp_ready_drive
      int stall_left;
      stall_left     = 0;
      found_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            stall_left--;
            found_ch.ready <= 1'b0;
         end else if (receiver_idles && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 15) - 1;
            found_ch.ready <= 1'b0;
         end else begin
            found_ch.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : found_check
      bit want;
      if (!reset && found_ch.valid === 1'b1 && found_ch.ready === 1'b1) begin
         if (found_q.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
               $display("unexpected result word: template_found=%b",
                        found_ch.template_found);
            end
         end else begin
            want = found_q.pop_front();
            if (found_ch.template_found !== want) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS) begin
                  $display("frame %0d: template_found expected %b, got %b",
                           results_checked, want, found_ch.template_found);
               end
            end
         end
         results_checked++;
      end
   end

   initial begin
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data   = 1'b0;
      pix_ch.valid     = 1'b0;
      pix_ch.pixel_rgb = '0;
      pix_ch.frame_end = 1'b0;
      for (int i = 0; i < WIN; i++) begin
         window_q[i] = '0;
      end
      fill_level      = 0;
      match_seen      = 1'b0;
      extra_on        = 1'b0;
      sender_idles    = 1'b0;
      receiver_idles  = 1'b0;
      words_sent      = 0;
      frames_done     = 0;
      frames_found    = 0;
      csr_writes      = 0;
      results_checked = 0;
      fail_count      = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_frames();
      test_random_frames(N_ITEMS - TAIL_ITEMS);
      test_quiet_tail(TAIL_ITEMS);

      $display("Sent %0d pixel words in %0d frames, %0d of them with a template found.",
               words_sent, frames_done, frames_found);
      $display("Extra-template register written %0d times; %0d result mismatches.",
               csr_writes, fail_count);
      if (fail_count == 0 && found_q.size() == 0) begin
         $display("tb_pixel_template_search_core OK");
      end else begin
         $display("tb_pixel_template_search_core NOT OK");
      end
      $finish;
   end

endmodule
